// ===== sv/wbm_pkg.sv =====
// Package with the types, codes and helpers of the watch button mode controller.
`timescale 1ns / 1ps

package wbm_pkg;

  // Watch modes, in the order the mode key steps through them.
  typedef enum logic [1:0] {
    MODE_CLOCK     = 2'd0,
    MODE_CORRECT   = 2'd1,
    MODE_STOPWATCH = 2'd2,
    MODE_COUNTDOWN = 2'd3
  } mode_t;

  // Beep requests.
  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_SHORT = 2'd1,
    BEEP_LONG  = 2'd2
  } beep_t;

  // Bit positions in a button sample.
  localparam int BTN_MODE = 0;
  localparam int BTN_LOW  = 1;
  localparam int BTN_MID  = 2;
  localparam int BTN_HIGH = 3;

  // Wrap points of the counters.
  localparam logic [6:0] HOUR_MOD    = 7'd24;
  localparam logic [6:0] MIN_SEC_MOD = 7'd60;
  localparam logic [6:0] CD_HOUR_MOD = 7'd100;
  localparam logic [6:0] CURSOR_MOD  = 7'd3;

  localparam logic [7:0] LIMIT_RESET = 8'd200;

  // Cursor positions in countdown mode.
  localparam logic [1:0] CURSOR_SEC  = 2'd0;
  localparam logic [1:0] CURSOR_MIN  = 2'd1;
  localparam logic [1:0] CURSOR_HOUR = 2'd2;

  // One result item.
  typedef struct packed {
    mode_t      mode;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] countdown_hours;
    logic [5:0] countdown_minutes;
    logic [5:0] countdown_seconds;
    logic [1:0] cursor_pos;
    logic [2:0] flags;
    logic       clear_pulse;
    beep_t      beep;
  } wbm_result_t;

  // Increment with wrap to zero at or above the modulus.
  function automatic logic [6:0] bump(input logic [6:0] v, input logic [6:0] modulus);
    logic [7:0] inc;
    begin
      inc = {1'b0, v} + 8'd1;
      bump = (inc >= {1'b0, modulus}) ? 7'd0 : inc[6:0];
    end
  endfunction

endpackage

// ===== sv/wbm_core.sv =====
// Watch state registers and the per-sample update logic.
`timescale 1ns / 1ps

module wbm_core import wbm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        step,
  input  logic [3:0]  buttons,
  output wbm_result_t result
);

  logic [7:0] limit_r;
  mode_t      mode_r, mode_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic [3:0] last_r;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [6:0] cd_hour_r, cd_hour_nxt;
  logic [5:0] cd_min_r, cd_min_nxt;
  logic [5:0] cd_sec_r, cd_sec_nxt;
  logic [1:0] cursor_r, cursor_nxt;
  logic       run_r, run_nxt;
  logic       lap_r, lap_nxt;
  logic       armed_r, armed_nxt;
  logic       clear_nxt;
  logic       long_beep, short_beep;
  logic       changed;
  logic [8:0] hold_inc;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Next state for one sample.
  always_comb begin
    mode_nxt    = mode_r;
    hold_nxt    = hold_r;
    hour_nxt    = hour_r;
    min_nxt     = min_r;
    sec_nxt     = sec_r;
    cd_hour_nxt = cd_hour_r;
    cd_min_nxt  = cd_min_r;
    cd_sec_nxt  = cd_sec_r;
    cursor_nxt  = cursor_r;
    run_nxt     = run_r;
    lap_nxt     = lap_r;
    armed_nxt   = armed_r;
    clear_nxt   = 1'b0;
    long_beep   = 1'b0;
    short_beep  = 1'b0;
    hold_inc    = {1'b0, hold_r} + 9'd1;
    changed     = (buttons != last_r);

    // Long press of the mode key steps the mode.
    if (buttons[BTN_MODE]) begin
      if (hold_inc >= {1'b0, limit_r}) begin
        hold_nxt  = 8'd0;
        mode_nxt  = mode_t'(mode_r + 2'd1);
        long_beep = 1'b1;
      end else begin
        hold_nxt = hold_inc[7:0];
      end
    end

    // Set buttons act on a changed sample, by the updated mode.
    if (changed) begin
      case (mode_nxt)
        MODE_STOPWATCH: begin
          if (buttons[BTN_HIGH]) begin
            run_nxt    = ~run_r;
            lap_nxt    = 1'b1;
            short_beep = 1'b1;
          end
          if (buttons[BTN_MID]) begin
            lap_nxt    = ~lap_nxt;
            short_beep = 1'b1;
          end
          if (buttons[BTN_LOW]) begin
            clear_nxt  = 1'b1;
            short_beep = 1'b1;
          end
        end
        MODE_CORRECT: begin
          if (buttons[BTN_HIGH]) begin
            hour_nxt   = 5'(bump({2'b0, hour_r}, HOUR_MOD));
            short_beep = 1'b1;
          end
          if (buttons[BTN_MID]) begin
            min_nxt    = 6'(bump({1'b0, min_r}, MIN_SEC_MOD));
            short_beep = 1'b1;
          end
          if (buttons[BTN_LOW]) begin
            sec_nxt    = 6'(bump({1'b0, sec_r}, MIN_SEC_MOD));
            short_beep = 1'b1;
          end
        end
        MODE_COUNTDOWN: begin
          if (buttons[BTN_HIGH]) begin
            armed_nxt  = 1'b1;
            short_beep = 1'b1;
          end
          // The field under the cursor as it stood before this sample.
          if (buttons[BTN_MID]) begin
            case (cursor_r)
              CURSOR_SEC:  cd_sec_nxt  = 6'(bump({1'b0, cd_sec_r}, MIN_SEC_MOD));
              CURSOR_MIN:  cd_min_nxt  = 6'(bump({1'b0, cd_min_r}, MIN_SEC_MOD));
              CURSOR_HOUR: cd_hour_nxt = bump(cd_hour_r, CD_HOUR_MOD);
              default:     cd_sec_nxt  = cd_sec_r;
            endcase
            short_beep = 1'b1;
          end
          if (buttons[BTN_LOW]) begin
            cursor_nxt = 2'(bump({5'b0, cursor_r}, CURSOR_MOD));
            short_beep = 1'b1;
          end
        end
        default: begin
          run_nxt = run_r;
        end
      endcase
    end
  end

  // State registers advance on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_COUNTDOWN;
      hold_r    <= 8'd0;
      last_r    <= 4'd0;
      hour_r    <= 5'd0;
      min_r     <= 6'd0;
      sec_r     <= 6'd0;
      cd_hour_r <= 7'd0;
      cd_min_r  <= 6'd0;
      cd_sec_r  <= 6'd0;
      cursor_r  <= 2'd0;
      run_r     <= 1'b0;
      lap_r     <= 1'b1;
      armed_r   <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      hold_r    <= hold_nxt;
      last_r    <= buttons;
      hour_r    <= hour_nxt;
      min_r     <= min_nxt;
      sec_r     <= sec_nxt;
      cd_hour_r <= cd_hour_nxt;
      cd_min_r  <= cd_min_nxt;
      cd_sec_r  <= cd_sec_nxt;
      cursor_r  <= cursor_nxt;
      run_r     <= run_nxt;
      lap_r     <= lap_nxt;
      armed_r   <= armed_nxt;
    end
  end

  // Result of this sample, taken by the output register.
  always_comb begin
    result.mode              = mode_nxt;
    result.hours             = hour_nxt;
    result.minutes           = min_nxt;
    result.seconds           = sec_nxt;
    result.countdown_hours   = cd_hour_nxt;
    result.countdown_minutes = cd_min_nxt;
    result.countdown_seconds = cd_sec_nxt;
    result.cursor_pos        = cursor_nxt;
    result.flags             = {armed_nxt, lap_nxt, run_nxt};
    result.clear_pulse       = clear_nxt;
    result.beep              = long_beep ? BEEP_LONG : (short_beep ? BEEP_SHORT : BEEP_NONE);
  end

endmodule

// ===== sv/wbm_out_reg.sv =====
// Output register of the result channel.
`timescale 1ns / 1ps

module wbm_out_reg import wbm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  wbm_result_t load_data,
  input  logic        out_ready,
  output logic        out_valid,
  output wbm_result_t out_data,
  output logic        can_load
);

  logic        valid_r;
  wbm_result_t data_r;

  // Room for a new result when empty or when the held one leaves now.
  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/watch_button_mode_controller.sv =====
// Top level of the watch button mode controller.
//
//   channel  direction  signals
//   in       request    in_valid, in_ready, in_buttons
//   out      result     out_valid, out_ready, out_mode ... out_beep
//   cfg      write      cfg_we, cfg_wdata (long press limit)
//
// One request is taken per cycle while in_ready is high; its result appears
// in the output register on the next cycle. The state update is a single
// level of compare and increment logic. Reset (synchronous, rst_n low) gives
// countdown mode, lap live and a limit of 200. A held result keeps in_ready
// low unless out_ready frees the output register in the same cycle.
`timescale 1ns / 1ps

module watch_button_mode_controller import wbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_buttons,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_mode,
  output logic [4:0] out_hours,
  output logic [5:0] out_minutes,
  output logic [5:0] out_seconds,
  output logic [6:0] out_countdown_hours,
  output logic [5:0] out_countdown_minutes,
  output logic [5:0] out_countdown_seconds,
  output logic [1:0] out_cursor_pos,
  output logic [2:0] out_flags,
  output logic       out_clear_pulse,
  output logic [1:0] out_beep
);

  wbm_result_t next_result;
  wbm_result_t held_result;
  logic        can_load;
  logic        step;

  assign in_ready = can_load;
  assign step     = in_valid && can_load;

  // State and update logic.
  wbm_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .step     (step),
    .buttons  (in_buttons),
    .result   (next_result)
  );

  // Result register.
  wbm_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .load_data(next_result),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (held_result),
    .can_load (can_load)
  );

  assign out_mode              = held_result.mode;
  assign out_hours             = held_result.hours;
  assign out_minutes           = held_result.minutes;
  assign out_seconds           = held_result.seconds;
  assign out_countdown_hours   = held_result.countdown_hours;
  assign out_countdown_minutes = held_result.countdown_minutes;
  assign out_countdown_seconds = held_result.countdown_seconds;
  assign out_cursor_pos        = held_result.cursor_pos;
  assign out_flags             = held_result.flags;
  assign out_clear_pulse       = held_result.clear_pulse;
  assign out_beep              = held_result.beep;

endmodule

// ===== tb/tb_watch_button_mode_controller.sv =====
// Self-checking testbench for the watch button mode controller.
`timescale 1ns / 1ps

module tb_watch_button_mode_controller import wbm_pkg::*; ();

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [3:0] in_buttons = 4'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_mode;
  logic [4:0] out_hours;
  logic [5:0] out_minutes;
  logic [5:0] out_seconds;
  logic [6:0] out_countdown_hours;
  logic [5:0] out_countdown_minutes;
  logic [5:0] out_countdown_seconds;
  logic [1:0] out_cursor_pos;
  logic [2:0] out_flags;
  logic       out_clear_pulse;
  logic [1:0] out_beep;

  watch_button_mode_controller u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_buttons           (in_buttons),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_mode             (out_mode),
    .out_hours            (out_hours),
    .out_minutes          (out_minutes),
    .out_seconds          (out_seconds),
    .out_countdown_hours  (out_countdown_hours),
    .out_countdown_minutes(out_countdown_minutes),
    .out_countdown_seconds(out_countdown_seconds),
    .out_cursor_pos       (out_cursor_pos),
    .out_flags            (out_flags),
    .out_clear_pulse      (out_clear_pulse),
    .out_beep             (out_beep)
  );

  // Button samples waiting to be sent, and watch states expected back.
  logic [3:0]  sample_q[$];
  wbm_result_t watch_state_q[$];

  int pushed_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int mode_steps = 0;
  int limit_writes = 0;
  int gap_pct = 10;
  int send_gap = 0;
  int recv_gap = 0;
  logic quiet = 1'b0;
  logic long_hold = 1'b0;

  // Shadow copy of the watch state, starting from its reset values.
  logic [7:0] press_limit = LIMIT_RESET;
  mode_t      cur_mode = MODE_COUNTDOWN;
  logic [7:0] held_samples = 8'd0;
  logic [3:0] prev_buttons = 4'd0;
  logic [4:0] clk_hour = 5'd0;
  logic [5:0] clk_min = 6'd0;
  logic [5:0] clk_sec = 6'd0;
  logic [6:0] cd_hour = 7'd0;
  logic [5:0] cd_min = 6'd0;
  logic [5:0] cd_sec = 6'd0;
  logic [1:0] cursor = 2'd0;
  logic       sw_running = 1'b0;
  logic       lap_live = 1'b1;
  logic       cd_armed = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Counter increment that wraps to zero at or above its modulus.
  function automatic int wrap_inc(input int value, input int modulus);
    return (value + 1 >= modulus) ? 0 : value + 1;
  endfunction

  // Advance the shadow state by one button sample and queue the state it yields.
  task automatic step_watch(input logic [3:0] b);
    wbm_result_t want;
    logic [8:0]  held_next;
    logic [1:0]  mode_next;
    logic        long_beep;
    logic        short_beep;
    logic        clear_now;
    long_beep = 1'b0;
    short_beep = 1'b0;
    clear_now = 1'b0;

    // A held mode key counts toward the long press.
    if (b[BTN_MODE]) begin
      held_next = {1'b0, held_samples} + 9'd1;
      if (held_next >= {1'b0, press_limit}) begin
        held_samples = 8'd0;
        mode_next = cur_mode;
        mode_next = mode_next + 2'd1;
        cur_mode = mode_t'(mode_next);
        long_beep = 1'b1;
        mode_steps++;
      end else begin
        held_samples = held_next[7:0];
      end
    end

    // A changed sample lets the set buttons act in the current mode.
    if (b != prev_buttons) begin
      prev_buttons = b;
      case (cur_mode)
        MODE_STOPWATCH: begin
          if (b[BTN_HIGH]) begin
            sw_running = ~sw_running;
            lap_live = 1'b1;
            short_beep = 1'b1;
          end
          if (b[BTN_MID]) begin
            lap_live = ~lap_live;
            short_beep = 1'b1;
          end
          if (b[BTN_LOW]) begin
            clear_now = 1'b1;
            short_beep = 1'b1;
          end
        end
        MODE_CORRECT: begin
          if (b[BTN_HIGH]) begin
            clk_hour = 5'(wrap_inc(clk_hour, HOUR_MOD));
            short_beep = 1'b1;
          end
          if (b[BTN_MID]) begin
            clk_min = 6'(wrap_inc(clk_min, MIN_SEC_MOD));
            short_beep = 1'b1;
          end
          if (b[BTN_LOW]) begin
            clk_sec = 6'(wrap_inc(clk_sec, MIN_SEC_MOD));
            short_beep = 1'b1;
          end
        end
        MODE_COUNTDOWN: begin
          if (b[BTN_HIGH]) begin
            cd_armed = 1'b1;
            short_beep = 1'b1;
          end
          if (b[BTN_MID]) begin
            case (cursor)
              CURSOR_SEC:  cd_sec = 6'(wrap_inc(cd_sec, MIN_SEC_MOD));
              CURSOR_MIN:  cd_min = 6'(wrap_inc(cd_min, MIN_SEC_MOD));
              CURSOR_HOUR: cd_hour = 7'(wrap_inc(cd_hour, CD_HOUR_MOD));
              default: ;
            endcase
            short_beep = 1'b1;
          end
          if (b[BTN_LOW]) begin
            cursor = 2'(wrap_inc(cursor, CURSOR_MOD));
            short_beep = 1'b1;
          end
        end
        default: ;
      endcase
    end

    want.mode = cur_mode;
    want.hours = clk_hour;
    want.minutes = clk_min;
    want.seconds = clk_sec;
    want.countdown_hours = cd_hour;
    want.countdown_minutes = cd_min;
    want.countdown_seconds = cd_sec;
    want.cursor_pos = cursor;
    want.flags = {cd_armed, lap_live, sw_running};
    want.clear_pulse = clear_now;
    want.beep = long_beep ? BEEP_LONG : (short_beep ? BEEP_SHORT : BEEP_NONE);
    watch_state_q.push_back(want);
  endtask

  function automatic void check_field(input string name, input int got, input int want);
    if (got != want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected %0d, got %0d", checked_count, name, want, got);
    end
  endfunction

  task automatic push_sample(input logic [3:0] b);
    sample_q.push_back(b);
    pushed_count++;
  endtask

  // Random sequences: press/release trains, long holds, noise and repeats.
  task automatic add_random(input int count, input int hold_pct);
    int         added;
    int         kind;
    int         len;
    logic [2:0] keys;
    logic [3:0] still;
    logic       press_key;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 24);
      keys = 3'($urandom_range(1, 7));
      still = 4'($urandom_range(0, 15));
      for (int i = 0; i < len; i++) begin
        press_key = ($urandom_range(0, 99) < hold_pct);
        if (kind <= 4)
          push_sample({((i % 2) == 0) ? keys : 3'b000, press_key});
        else if (kind <= 6)
          push_sample({keys, 1'b1});
        else if (kind <= 8)
          push_sample(4'($urandom_range(0, 15)));
        else
          push_sample(still);
        added++;
      end
    end
  endtask

  // Wait until every sent request has produced its checked result.
  task automatic wait_idle();
    while (checked_count != pushed_count) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_press_limit(input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    press_limit = value;
    limit_writes++;
  endtask

  // Request driver: holds each sample until accepted, with random gaps.
  always @(posedge clk) begin : drive_requests
    logic       fire;
    logic       valid_next;
    logic [3:0] buttons_next;
    fire = in_valid && in_ready;
    valid_next = in_valid && !fire;
    buttons_next = in_buttons;
    if (!rst_n) begin
      valid_next = 1'b0;
      send_gap = 0;
    end else begin
      if (fire) step_watch(in_buttons);
      if (!valid_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
          send_gap = $urandom_range(0, 11);
        end else if (sample_q.size() > 0) begin
          valid_next = 1'b1;
          buttons_next = sample_q.pop_front();
        end
      end
    end
    in_valid <= valid_next;
    in_buttons <= buttons_next;
  end

  // Result monitor: compares each accepted result and stalls at random.
  always @(posedge clk) begin : check_results
    wbm_result_t want;
    logic        ready_next;
    ready_next = 1'b1;
    if (!rst_n) begin
      ready_next = 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (watch_state_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: mode %0d beep %0d", out_mode, out_beep);
        end else begin
          want = watch_state_q.pop_front();
          check_field("mode", out_mode, want.mode);
          check_field("hours", out_hours, want.hours);
          check_field("minutes", out_minutes, want.minutes);
          check_field("seconds", out_seconds, want.seconds);
          check_field("countdown_hours", out_countdown_hours, want.countdown_hours);
          check_field("countdown_minutes", out_countdown_minutes, want.countdown_minutes);
          check_field("countdown_seconds", out_countdown_seconds, want.countdown_seconds);
          check_field("cursor_pos", out_cursor_pos, want.cursor_pos);
          check_field("flags", out_flags, want.flags);
          check_field("clear_pulse", out_clear_pulse, want.clear_pulse);
          check_field("beep", out_beep, want.beep);
          checked_count++;
        end
      end
      if (long_hold) begin
        ready_next = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        recv_gap = $urandom_range(0, 11);
        ready_next = 1'b0;
      end
    end
    out_ready <= ready_next;
  end

  // Long receiver hold-off so the block fills and back-pressures its input.
  initial begin : receiver_hold_off
    wait (checked_count >= 120);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (80) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Run limit.
  initial begin : run_limit
    #2000000;
    $display("timed out with %0d of %0d results checked", checked_count, pushed_count);
    $display("watch_button_mode_controller regression: fail");
    $finish;
  end

  // Phases of stimulus, each under its own long press limit.
  initial begin : run_phases
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Countdown mode from reset: arm, bump under each cursor, cursor wrap,
    // all set buttons, and all buttons with the mode key.
    push_sample(4'b1000); push_sample(4'b0100); push_sample(4'b0010);
    push_sample(4'b0110); push_sample(4'b0100); push_sample(4'b0000);
    push_sample(4'b0010); push_sample(4'b1110); push_sample(4'b1111);
    push_sample(4'b0000);
    wait_idle();

    // Limit of one: each held sample steps the mode. Visit clock mode with
    // set buttons, correct mode bumps, a mode step with beeps of both kinds,
    // start and lap together, and the stopwatch clear.
    set_press_limit(8'd1);
    push_sample(4'b0001); push_sample(4'b1110); push_sample(4'b0000);
    push_sample(4'b0001); push_sample(4'b0000); push_sample(4'b1000);
    push_sample(4'b0100); push_sample(4'b0010); push_sample(4'b1110);
    push_sample(4'b1111); push_sample(4'b0000); push_sample(4'b1000);
    push_sample(4'b0100); push_sample(4'b1100); push_sample(4'b0010);
    push_sample(4'b0000); push_sample(4'b0001);
    wait_idle();

    // Largest limit with the mode key held most of the time.
    set_press_limit(8'd255);
    gap_pct <= 10;
    add_random(300, 92);
    wait_idle();

    // Small limit right after a long count, so the held count may exceed it.
    set_press_limit(8'd2);
    gap_pct <= 35;
    add_random(100, 30);
    wait_idle();

    set_press_limit(8'($urandom_range(3, 12)));
    gap_pct <= 15;
    add_random(100, 45);
    wait_idle();

    set_press_limit(LIMIT_RESET);
    gap_pct <= 0;
    add_random(60, 60);
    wait_idle();

    // Closing stretch without any idling.
    set_press_limit(8'd1);
    quiet <= 1'b1;
    add_random(50, 25);
    wait_idle();
    repeat (4) @(posedge clk);

    $display("Checked %0d button samples under %0d limit settings.", checked_count,
             limit_writes + 1);
    $display("The model stepped the mode %0d times; %0d mismatches seen.", mode_steps,
             mismatch_count);
    if (mismatch_count == 0 && watch_state_q.size() == 0)
      $display("watch_button_mode_controller regression: pass");
    else
      $display("watch_button_mode_controller regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wbm_pkg.sv
sv/wbm_core.sv
sv/wbm_out_reg.sv
sv/watch_button_mode_controller.sv
tb/tb_watch_button_mode_controller.sv
